@@ design/kcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcr_pkg
// Shared constants, request types and helpers for the keyframe cloud
// retention block.
// ----------------------------------------------------------------------------
package kcr_pkg;

	localparam int N    = 64;
	localparam int IW   = 6;
	localparam int CW   = 7;
	localparam int AXIS = 21;
	localparam int KW   = 3 * AXIS;
	localparam int TW   = 32;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [1:0] REG_VOXEL_ENABLE = 2'd0;
	localparam logic [1:0] REG_VOXEL_SHIFT  = 2'd1;
	localparam logic [1:0] REG_RECENT_WIN   = 2'd2;
	localparam logic [1:0] REG_MAX_CLOUD    = 2'd3;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	typedef struct packed {
		logic          add_en;
		logic          sel_en;
		logic          own_en;
		logic          drop_en;
		logic [IW-1:0] idx;
		logic [TW-1:0] stamp;
		logic          bearing;
		logic [KW-1:0] key;
	} kcr_cmd_t;

	typedef struct packed {
		logic          by_time;
		logic          ve;
		logic [TW-1:0] now;
		logic [TW-1:0] window;
		logic [KW-1:0] key;
	} kcr_qry_t;

	typedef struct packed {
		logic          found;
		logic          held;
		logic [TW-1:0] val;
		logic [IW-1:0] idx;
	} kcr_link_t;

	function automatic logic [AXIS-1:0] axis_cell(input logic [31:0] pos,
		input logic [4:0] sh);
		logic signed [31:0] t;
		t = $signed(pos) >>> sh;
		return t[AXIS-1:0];
	endfunction

endpackage

@@ design/kcr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcr_cell
// One table entry plus one stage of the search chain; merges its own
// candidate and ownership match into the link from the lower neighbor.
// ----------------------------------------------------------------------------
module kcr_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [kcr_pkg::IW-1:0] cell_id,
	input  kcr_pkg::kcr_cmd_t      cmd,
	input  kcr_pkg::kcr_qry_t      qry,
	input  kcr_pkg::kcr_link_t     link_in,
	output kcr_pkg::kcr_link_t     link_q
);

	logic [kcr_pkg::TW-1:0] stamp_q;
	logic [kcr_pkg::TW-1:0] lst_q;
	logic [kcr_pkg::KW-1:0] key_q;
	logic                   bearing_q;
	logic                   owner_q;
	logic                   hit;
	logic [kcr_pkg::TW:0]   age;
	logic                   prot;
	logic                   cand;
	logic [kcr_pkg::TW-1:0] val;
	logic                   take;
	kcr_pkg::kcr_link_t     link_d;

	assign hit = (cmd.idx == cell_id);

	always_ff @(posedge clk) begin
		if (cmd.add_en && hit) begin
			stamp_q <= cmd.stamp;
		end
		if ((cmd.add_en || cmd.sel_en) && hit) begin
			lst_q <= cmd.stamp;
		end
		if (cmd.own_en && hit) begin
			key_q <= cmd.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bearing_q <= 1'b0;
			owner_q   <= 1'b0;
		end else if (hit) begin
			if (cmd.add_en) begin
				bearing_q <= cmd.bearing;
				owner_q   <= 1'b0;
			end
			if (cmd.own_en) begin
				owner_q <= 1'b1;
			end
			if (cmd.drop_en) begin
				bearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		age  = {1'b0, qry.now} - {1'b0, stamp_q};
		prot = (cell_id == '0) || ($signed(age) <= $signed({1'b0, qry.window}));
		cand = bearing_q && !prot && (qry.by_time || (qry.ve && !owner_q));
		val  = qry.by_time ? lst_q : '0;
		take = cand && (!link_in.found || (val < link_in.val));
		link_d.found = link_in.found || take;
		link_d.val   = take ? val : link_in.val;
		link_d.idx   = take ? cell_id : link_in.idx;
		link_d.held  = link_in.held || (owner_q && (key_q == qry.key));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_d;
		end
	end

endmodule

@@ design/keyframe_cloud_retention.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_cloud_retention
// Keyframe table with voxel ownership and cloud eviction over a cell chain.
// ----------------------------------------------------------------------------
// select and refused add: the result is registered in the cycle after the request
// add: a chain search for the claim when the entry may claim a cell,
//   then one search per eviction plus one closing search per pass that runs,
//   then states S_RD and S_OUT per eviction result, or S_ONE for a lone result
// each search waits for a change to ripple down the 64-stage chain
// reset clears the table flags and counts and restores the configuration defaults at once; no sweep
module keyframe_cloud_retention (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [31:0]     pos_z,
	input  logic [31:0]            time_stamp,
	input  logic                   poor_quality,
	input  logic                   has_cloud,
	input  logic [5:0]             entry_index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [5:0]             assigned_index,
	output logic                   claimed_cell,
	output logic                   evict_valid,
	output logic [5:0]             evicted_index,
	output logic [6:0]             bearing_count,
	output logic                   last
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLAIM = 7'b0000010,
		S_P1    = 7'b0000100,
		S_P2    = 7'b0001000,
		S_RD    = 7'b0010000,
		S_OUT   = 7'b0100000,
		S_ONE   = 7'b1000000
	} state_t;

	localparam logic [kcr_pkg::CW-1:0] SETTLE = kcr_pkg::CW'(kcr_pkg::N + 1);

	state_t                 state_q;
	logic                   ve_q;
	logic [4:0]             sh_q;
	logic [31:0]            win_q;
	logic [kcr_pkg::CW-1:0] cap_q;
	logic [kcr_pkg::CW-1:0] count_q;
	logic [kcr_pkg::CW-1:0] bc_q;
	logic [kcr_pkg::IW-1:0] idx_q;
	logic [kcr_pkg::TW-1:0] now_q;
	logic [kcr_pkg::KW-1:0] key_q;
	logic                   claim_q;
	logic [kcr_pkg::CW-1:0] wait_q;
	logic [kcr_pkg::CW-1:0] wr_q;
	logic [kcr_pkg::IW-1:0] rd_q;
	logic [kcr_pkg::IW-1:0] rd_data_q;
	logic [kcr_pkg::IW-1:0] ev_mem [kcr_pkg::N];

	logic                   free;
	logic                   acc;
	logic                   settled;
	logic                   push;
	logic                   res_load;
	logic [kcr_pkg::KW-1:0] key_in;
	kcr_pkg::kcr_cmd_t      cmd;
	kcr_pkg::kcr_qry_t      qry;
	kcr_pkg::kcr_link_t     links [kcr_pkg::N];
	kcr_pkg::kcr_link_t     tail;

	assign cfg_ready = 1'b1;
	assign free      = !out_valid || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && free);
	assign acc       = in_valid && !in_stall;
	assign settled   = (wait_q == '0);
	assign tail      = links[kcr_pkg::N-1];
	assign key_in    = {kcr_pkg::axis_cell(pos_x, sh_q), kcr_pkg::axis_cell(pos_y, sh_q),
		kcr_pkg::axis_cell(pos_z, sh_q)};

	assign push = settled && tail.found &&
		((state_q == S_P1) || ((state_q == S_P2) && (bc_q > cap_q)));

	assign res_load = free && (((state_q == S_IDLE) && acc &&
		((op == kcr_pkg::OP_SELECT) || !cmd.add_en)) ||
		(state_q == S_OUT) || (state_q == S_ONE));

	assign qry.by_time = (state_q == S_P2);
	assign qry.ve      = ve_q;
	assign qry.now     = now_q;
	assign qry.window  = win_q;
	assign qry.key     = key_q;

	always_comb begin
		cmd = '0;
		if (acc) begin
			cmd.stamp = time_stamp;
			if (op == kcr_pkg::OP_SELECT) begin
				cmd.idx    = entry_index;
				cmd.sel_en = ({1'b0, entry_index} < count_q);
			end else begin
				cmd.idx     = count_q[kcr_pkg::IW-1:0];
				cmd.add_en  = (count_q < kcr_pkg::CW'(kcr_pkg::N));
				cmd.bearing = has_cloud;
			end
		end else if ((state_q == S_CLAIM) && settled) begin
			cmd.idx    = idx_q;
			cmd.key    = key_q;
			cmd.own_en = !tail.held;
		end else if (push) begin
			cmd.idx     = tail.idx;
			cmd.drop_en = 1'b1;
		end
	end

	genvar g;
	generate
		for (g = 0; g < kcr_pkg::N; g++) begin : g_cell
			kcr_pkg::kcr_link_t lin;
			if (g == 0) begin : g_head
				assign lin = '0;
			end else begin : g_body
				assign lin = links[g-1];
			end
			kcr_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cell_id (kcr_pkg::IW'(g)),
				.cmd     (cmd),
				.qry     (qry),
				.link_in (lin),
				.link_q  (links[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (push) begin
			ev_mem[wr_q[kcr_pkg::IW-1:0]] <= tail.idx;
		end
		rd_data_q <= ev_mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (acc && (op == kcr_pkg::OP_ADD)) begin
			idx_q   <= count_q[kcr_pkg::IW-1:0];
			now_q   <= time_stamp;
			key_q   <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ve_q           <= 1'b1;
			sh_q           <= 5'd10;
			win_q          <= 32'd5000;
			cap_q          <= '0;
			count_q        <= '0;
			bc_q           <= '0;
			claim_q        <= 1'b0;
			wait_q         <= '0;
			wr_q           <= '0;
			rd_q           <= '0;
			out_valid      <= 1'b0;
			status         <= kcr_pkg::ST_OK;
			assigned_index <= '0;
			claimed_cell   <= 1'b0;
			evict_valid    <= 1'b0;
			evicted_index  <= '0;
			bearing_count  <= '0;
			last           <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kcr_pkg::REG_VOXEL_ENABLE: ve_q  <= cfg_data[0];
					kcr_pkg::REG_VOXEL_SHIFT:  sh_q  <= cfg_data[4:0];
					kcr_pkg::REG_RECENT_WIN:   win_q <= cfg_data;
					kcr_pkg::REG_MAX_CLOUD:    cap_q <= cfg_data[kcr_pkg::CW-1:0];
					default:                   ve_q  <= ve_q;
				endcase
			end
			if (out_valid && !out_stall && !res_load) begin
				out_valid <= 1'b0;
			end
			if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
			if (push) begin
				wr_q   <= wr_q + 1'b1;
				bc_q   <= bc_q - 1'b1;
				wait_q <= SETTLE;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						assigned_index <= '0;
						claimed_cell   <= 1'b0;
						evict_valid    <= 1'b0;
						evicted_index  <= '0;
						bearing_count  <= bc_q;
						last           <= 1'b1;
						if (op == kcr_pkg::OP_SELECT) begin
							out_valid <= 1'b1;
							status    <= cmd.sel_en ? kcr_pkg::ST_OK : kcr_pkg::ST_BAD;
						end else if (!cmd.add_en) begin
							out_valid <= 1'b1;
							status    <= kcr_pkg::ST_FULL;
						end else begin
							count_q <= count_q + 1'b1;
							bc_q    <= bc_q + kcr_pkg::CW'(has_cloud);
							claim_q <= 1'b0;
							wr_q    <= '0;
							if (has_cloud && ve_q && !poor_quality) begin
								wait_q  <= SETTLE;
								state_q <= S_CLAIM;
							end else if (ve_q || (cap_q != '0)) begin
								wait_q  <= SETTLE;
								state_q <= S_P1;
							end else begin
								state_q <= S_ONE;
							end
						end
					end
				end
				S_CLAIM: begin
					if (settled) begin
						claim_q <= !tail.held;
						if (ve_q || (cap_q != '0)) begin
							wait_q  <= SETTLE;
							state_q <= S_P1;
						end else begin
							state_q <= S_ONE;
						end
					end
				end
				S_P1: begin
					if (settled && !tail.found) begin
						if ((cap_q != '0) && (bc_q > cap_q)) begin
							wait_q  <= SETTLE;
							state_q <= S_P2;
						end else begin
							rd_q    <= '0;
							state_q <= (wr_q == '0) ? S_ONE : S_RD;
						end
					end
				end
				S_P2: begin
					if (settled && !push) begin
						rd_q    <= '0;
						state_q <= (wr_q == '0) ? S_ONE : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (free) begin
						out_valid      <= 1'b1;
						status         <= kcr_pkg::ST_OK;
						assigned_index <= idx_q;
						claimed_cell   <= claim_q;
						evict_valid    <= 1'b1;
						evicted_index  <= rd_data_q;
						bearing_count  <= bc_q;
						last           <= ({1'b0, rd_q} + 1'b1 == wr_q);
						rd_q           <= rd_q + 1'b1;
						state_q        <= ({1'b0, rd_q} + 1'b1 == wr_q) ? S_IDLE : S_RD;
					end
				end
				S_ONE: begin
					if (free) begin
						out_valid      <= 1'b1;
						status         <= kcr_pkg::ST_OK;
						assigned_index <= idx_q;
						claimed_cell   <= claim_q;
						evict_valid    <= 1'b0;
						evicted_index  <= '0;
						bearing_count  <= bc_q;
						last           <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (state_q == S_IDLE))
		else $error("request taken outside idle");
	a_bc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= count_q)
		else $error("bearing count above entry count");
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= kcr_pkg::CW'(kcr_pkg::N))
		else $error("eviction list overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_OUT) && !free) |=> (state_q == S_OUT))
		else $error("result lost under stall");

endmodule
